/* hw/rtl/i2csbe_pkg.sv */
// Shared types and constants for the I2C slave buffer engine.
package i2csbe_pkg;

	localparam int BUF_DEPTH_DEF = 32;
	localparam int LEN_W         = 6;
	localparam int BYTE_W        = 8;
	localparam int IDX_W         = 5;
	localparam int KIND_W        = 3;
	localparam int RES_W         = 3;
	localparam int CFG_IDX_W     = 1;

	typedef enum logic [KIND_W-1:0] {
		KIND_BUS   = 3'd0,
		KIND_LOAD  = 3'd1,
		KIND_READ  = 3'd2,
		KIND_TAKE  = 3'd3,
		KIND_CLEAR = 3'd4
	} kind_t;

	typedef enum logic [RES_W-1:0] {
		RES_WAIT     = 3'd0,
		RES_RECEIVED = 3'd1,
		RES_SENT     = 3'd2,
		RES_NACK     = 3'd3,
		RES_ERROR    = 3'd4
	} res_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RECV_LEN = 1'd0,
		REG_SEND_LEN = 1'd1
	} cfg_reg_t;

	// status codes, prescaler bits masked
	localparam logic [7:0] CODE_MASK       = 8'hF8;
	localparam logic [7:0] CODE_BUS_ERR    = 8'h00;
	localparam logic [7:0] CODE_SR_ADDR    = 8'h60;
	localparam logic [7:0] CODE_SR_ARB     = 8'h68;
	localparam logic [7:0] CODE_SR_GEN     = 8'h70;
	localparam logic [7:0] CODE_SR_GEN_ARB = 8'h78;
	localparam logic [7:0] CODE_SR_DATA    = 8'h80;
	localparam logic [7:0] CODE_SR_NACK    = 8'h88;
	localparam logic [7:0] CODE_SR_GDATA   = 8'h90;
	localparam logic [7:0] CODE_SR_GNACK   = 8'h98;
	localparam logic [7:0] CODE_SR_STOP    = 8'hA0;
	localparam logic [7:0] CODE_ST_ADDR    = 8'hA8;
	localparam logic [7:0] CODE_ST_ARB     = 8'hB0;
	localparam logic [7:0] CODE_ST_DATA    = 8'hB8;
	localparam logic [7:0] CODE_ST_NACK    = 8'hC0;
	localparam logic [7:0] CODE_ST_LAST    = 8'hC8;

endpackage

/* hw/rtl/i2csbe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module i2csbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/i2c_slave_buffer_engine_core.sv */
// Top level of the I2C slave buffer engine: event decode, state and stores.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   kind status_code bus_byte host_index host_data
//  out      output     out_valid / out_stall tx_byte ack send_stop result_code busy_res
//                                            done_res last_length last_direction read_data fault
//  cfg      input      cfg_we                cfg_index cfg_wdata
//
// One item per cycle while the output is not stalled; an accepted item passes the input register,
// then the result register, with the store read landing alongside the result register.
// Reset clears control state; store contents are undefined until written.
// An output stall holds the result and backs up into in_stall after one more item.
module i2c_slave_buffer_engine_core #(
	parameter int BUF_DEPTH = i2csbe_pkg::BUF_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [i2csbe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [i2csbe_pkg::LEN_W-1:0]        cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [i2csbe_pkg::KIND_W-1:0]       kind,
	input  logic [7:0]                          status_code,
	input  logic [i2csbe_pkg::BYTE_W-1:0]       bus_byte,
	input  logic [i2csbe_pkg::IDX_W-1:0]        host_index,
	input  logic [i2csbe_pkg::BYTE_W-1:0]       host_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [i2csbe_pkg::BYTE_W-1:0]       tx_byte,
	output logic                                ack,
	output logic                                send_stop,
	output logic [i2csbe_pkg::RES_W-1:0]        result_code,
	output logic                                busy_res,
	output logic                                done_res,
	output logic [i2csbe_pkg::LEN_W-1:0]        last_length,
	output logic                                last_direction,
	output logic [i2csbe_pkg::BYTE_W-1:0]       read_data,
	output logic                                fault
);

	import i2csbe_pkg::*;

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam logic [8:0] DEPTH_9 = 9'(BUF_DEPTH);
	localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(BUF_DEPTH);

	// configuration
	logic [LEN_W-1:0] recv_len_q, send_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_len_q <= '0;
			send_len_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RECV_LEN: recv_len_q <= cfg_wdata;
				REG_SEND_LEN: send_len_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	logic                 valid_s1;
	logic [KIND_W-1:0]    kind_s1;
	logic [7:0]           code_s1;
	logic [BYTE_W-1:0]    bus_byte_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [BYTE_W-1:0]    hdata_s1;
	logic                 adv_s1;
	logic                 valid_s2;

	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1     <= kind;
			code_s1     <= status_code;
			bus_byte_s1 <= bus_byte;
			idx_s1      <= host_index;
			hdata_s1    <= host_data;
		end
	end

	// transaction state
	logic [LEN_W-1:0] pos_q, pos_d;
	logic             busy_q, busy_d;
	logic             dir_q, dir_d;
	res_t             res_q, res_d;
	logic [LEN_W-1:0] llen_q, llen_d;
	logic             ldir_q, ldir_d;

	logic [LEN_W-1:0] rlen, slen, st_pos;
	logic [7:0]       code_m;
	logic             enabled, idx_ok;
	logic             ack_c, stop_c, done_c, fault_c, tx_rd, rx_rd;
	logic             recv_we, send_we;
	logic [AW-1:0]    send_raddr;

	assign rlen    = (9'(recv_len_q) > DEPTH_9) ? DEPTH_LEN : recv_len_q;
	assign slen    = (9'(send_len_q) > DEPTH_9) ? DEPTH_LEN : send_len_q;
	assign code_m  = code_s1 & CODE_MASK;
	assign enabled = (recv_len_q != '0) && (send_len_q != '0);
	assign idx_ok  = 9'(idx_s1) < DEPTH_9;
	assign st_pos  = (code_m == CODE_ST_DATA) ? pos_q : '0;

	always_comb begin
		pos_d      = pos_q;
		busy_d     = busy_q;
		dir_d      = dir_q;
		res_d      = res_q;
		llen_d     = llen_q;
		ldir_d     = ldir_q;
		ack_c      = 1'b0;
		stop_c     = 1'b0;
		done_c     = 1'b0;
		fault_c    = 1'b0;
		tx_rd      = 1'b0;
		rx_rd      = 1'b0;
		recv_we    = 1'b0;
		send_we    = 1'b0;
		send_raddr = AW'(st_pos);
		case (kind_s1)
			KIND_BUS: begin
				if (enabled || busy_q) begin
					case (code_m)
						CODE_BUS_ERR: begin
							busy_d = 1'b0;
							res_d  = RES_ERROR;
							stop_c = 1'b1;
						end
						CODE_SR_ADDR, CODE_SR_ARB, CODE_SR_GEN, CODE_SR_GEN_ARB: begin
							busy_d = 1'b1;
							pos_d  = '0;
							dir_d  = 1'b0;
							ack_c  = 1'b1;
						end
						CODE_SR_DATA, CODE_SR_GDATA: begin
							if (pos_q >= rlen) begin
								res_d = RES_NACK;
							end else begin
								recv_we = 1'b1;
								pos_d   = LEN_W'(pos_q + 1'b1);
								ack_c   = 1'b1;
							end
						end
						CODE_ST_ADDR, CODE_ST_ARB, CODE_ST_DATA: begin
							if (code_m != CODE_ST_DATA) begin
								busy_d = 1'b1;
								dir_d  = 1'b1;
							end
							pos_d = st_pos;
							if (st_pos < slen) begin
								tx_rd = 1'b1;
								pos_d = LEN_W'(st_pos + 1'b1);
							end
							ack_c = 1'b1;
						end
						CODE_ST_LAST, CODE_ST_NACK, CODE_SR_NACK, CODE_SR_GNACK,
						CODE_SR_STOP: begin
							llen_d = pos_q;
							ldir_d = dir_q;
							res_d  = dir_q ? RES_SENT : RES_RECEIVED;
							done_c = 1'b1;
							busy_d = 1'b0;
							ack_c  = 1'b1;
						end
						default: fault_c = 1'b1;
					endcase
				end
			end
			KIND_LOAD: send_we = idx_ok;
			KIND_READ: rx_rd = idx_ok;
			KIND_TAKE: begin
				if (res_q == RES_RECEIVED || res_q == RES_SENT) begin
					res_d = RES_WAIT;
				end
			end
			KIND_CLEAR: res_d = RES_WAIT;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			busy_q <= 1'b0;
			dir_q  <= 1'b0;
			res_q  <= RES_WAIT;
			llen_q <= '0;
			ldir_q <= 1'b0;
		end else if (adv_s1) begin
			pos_q  <= pos_d;
			busy_q <= busy_d;
			dir_q  <= dir_d;
			res_q  <= res_d;
			llen_q <= llen_d;
			ldir_q <= ldir_d;
		end
	end

	// stores
	logic [BYTE_W-1:0] send_rdata, recv_rdata;

	i2csbe_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BUF_DEPTH)
	) u_send_store (
		.clk   (clk),
		.we    (adv_s1 && send_we),
		.waddr (AW'(idx_s1)),
		.wdata (hdata_s1),
		.re    (adv_s1 && tx_rd),
		.raddr (send_raddr),
		.rdata (send_rdata)
	);

	i2csbe_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BUF_DEPTH)
	) u_recv_store (
		.clk   (clk),
		.we    (adv_s1 && recv_we),
		.waddr (AW'(pos_q)),
		.wdata (bus_byte_s1),
		.re    (adv_s1 && rx_rd),
		.raddr (AW'(idx_s1)),
		.rdata (recv_rdata)
	);

	// result register
	logic             tx_sel_s2, rd_sel_s2;
	logic             ack_s2, stop_s2, done_s2, fault_s2, busy_s2, ldir_s2;
	res_t             res_s2;
	logic [LEN_W-1:0] llen_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= adv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			tx_sel_s2 <= tx_rd;
			rd_sel_s2 <= rx_rd;
			ack_s2    <= ack_c;
			stop_s2   <= stop_c;
			done_s2   <= done_c;
			fault_s2  <= fault_c;
			busy_s2   <= busy_d;
			res_s2    <= res_d;
			llen_s2   <= llen_d;
			ldir_s2   <= ldir_d;
		end
	end

	assign out_valid      = valid_s2;
	assign tx_byte        = tx_sel_s2 ? send_rdata : '0;
	assign read_data      = rd_sel_s2 ? recv_rdata : '0;
	assign ack            = ack_s2;
	assign send_stop      = stop_s2;
	assign result_code    = res_s2;
	assign busy_res       = busy_s2;
	assign done_res       = done_s2;
	assign last_length    = llen_s2;
	assign last_direction = ldir_s2;
	assign fault          = fault_s2;

endmodule
